### src/stlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlc_pkg
// Shared types and constants of the sampled trajectory limit checker.
// ----------------------------------------------------------------------------
package stlc_pkg;

   // Microseconds per second as a 20-bit constant multiplier
   localparam int unsigned USEC_BITS = 20;
   localparam logic [USEC_BITS-1:0] USEC_PER_SEC = 20'd1000000;

   // Q16.16 one, scale ceiling, saturated norm
   localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
   localparam logic [23:0] SCALE_MAX = 24'hFF_FFFF;
   localparam logic [31:0] NORM_MAX  = 32'hFFFF_FFFF;

   // Configuration register indexes
   localparam logic [1:0] CSR_SPEED_LIMIT    = 2'd0;
   localparam logic [1:0] CSR_SPEED_ENABLE   = 2'd1;
   localparam logic [1:0] CSR_ACCEL_LIMIT    = 2'd2;
   localparam logic [1:0] CSR_ACCEL_ENABLE   = 2'd3;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIFF,
      ST_MUL,
      ST_DIV,
      ST_DIV_WAIT,
      ST_SQ,
      ST_SUM,
      ST_ROOT,
      ST_ROOT_WAIT,
      ST_COMMIT_V,
      ST_COMMIT,
      ST_FIN_S,
      ST_FIN_S_WAIT,
      ST_FIN_A,
      ST_FIN_A_WAIT,
      ST_FIN_A_ROOT,
      ST_OUT
   } stlc_state_type;

endpackage

### src/stlc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlc_div
// Restoring divider, one quotient bit per cycle, 32-bit nonzero divisor.
// ----------------------------------------------------------------------------
module stlc_div #(
   parameter int NUM_W = 69
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [31:0]      den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [32:0]      trial;
   logic [32:0]      diff;

   // One restoring step: bring down the next numerator bit
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

### src/stlc_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlc_isqrt
// Floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module stlc_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] rad_ff, rad_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] part;
   logic [34:0] trial;
   logic [34:0] diff;

   // Bring down two radicand bits and try the next root bit
   always_comb begin
      part    = {rem_ff, rad_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = part - trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (part >= trial) begin
            rem_in  = diff[32:0];
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = part[32:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### src/sampled_trajectory_limit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampled_trajectory_limit_checker
// Finite-difference speed and acceleration check of timestamped 3D samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Limits are written on the csr_ port (index 0..3) while the block is idle.
//  - Samples enter on req_ (valid/ready). first_sample clears the run,
//    last_sample makes one summary item appear on rsp_ (valid/ready).
//  - req_ready is high only while the sequencer is idle; one item is worked
//    on at a time. A sample with a rising timestamp forms three velocity
//    components, each a shift-add by 1e6 and a restoring division of an
//    N-bit numerator (N = max(WORD_WIDTH+21, 64)), then a 3-square sum and
//    a root. With a valid previous velocity the same runs again for
//    acceleration. The summary adds up to two more divisions and one root.
//  - The summary sits in an output register; the next sample is taken while
//    it waits. A second summary waits until the first one is taken.
//  - Reset clears the limits, the run state and the output valid.
// ----------------------------------------------------------------------------
module sampled_trajectory_limit_checker
   import stlc_pkg::*;
#(
   parameter int WORD_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   // sample input
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_sample_time,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic               req_first_sample,
   input  logic               req_last_sample,
   // summary output
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_feasible,
   output logic               rsp_speed_violation,
   output logic               rsp_accel_violation,
   output logic               rsp_violation_time_valid,
   output logic [31:0]        rsp_first_viol_time,
   output logic [31:0]        rsp_peak_speed,
   output logic [31:0]        rsp_peak_accel,
   output logic [23:0]        rsp_time_scale,
   output logic               rsp_time_scale_unbounded
);

   localparam int WW   = WORD_WIDTH;
   localparam int MW   = (WW + 1 > 33) ? WW + 1 : 33;
   localparam int NW   = (MW + USEC_BITS > 64) ? MW + USEC_BITS : 64;
   localparam logic [NW-1:0] CAP_POS = NW'((65'd1 << (WW - 1)) - 65'd1);
   localparam logic [NW-1:0] CAP_NEG = NW'(65'd1 << (WW - 1));

   // configuration registers
   logic [31:0] slim_ff, alim_ff;
   logic        sen_ff, aen_ff;

   // sequencer and sample
   stlc_state_type    state_ff, state_in;
   logic [31:0]       t_ff, t_in;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic              last_ff, last_in;

   // run state
   logic              have_prev_ff, have_prev_in;
   logic [31:0]       prev_time_ff, prev_time_in;
   logic signed [31:0] prev_pos_ff [3];
   logic signed [31:0] prev_pos_in [3];
   logic              have_pvel_ff, have_pvel_in;
   logic signed [WW-1:0] pvel_ff [3];
   logic signed [WW-1:0] pvel_in [3];
   logic [31:0]       pvel_time_ff, pvel_time_in;
   logic [31:0]       max_speed_ff, max_speed_in;
   logic [31:0]       max_accel_ff, max_accel_in;
   logic              sflag_ff, sflag_in;
   logic              aflag_ff, aflag_in;
   logic              ftv_ff, ftv_in;
   logic [31:0]       ft_ff, ft_in;

   // work registers
   logic              phase_acc_ff, phase_acc_in;
   logic [1:0]        idx_ff, idx_in;
   logic [31:0]       den_ff, den_in;
   logic [NW-1:0]     mcand_ff, mcand_in;
   logic [NW-1:0]     prod_ff, prod_in;
   logic [4:0]        mcnt_ff, mcnt_in;
   logic              neg_ff, neg_in;
   logic signed [WW-1:0] vel_ff [3];
   logic signed [WW-1:0] vel_in [3];
   logic signed [WW-1:0] accv_ff [3];
   logic signed [WW-1:0] accv_in [3];
   logic [63:0]       sq_ff, sq_in;
   logic              big_ff, big_in;
   logic [63:0]       sum_ff, sum_in;
   logic              ovf_ff, ovf_in;
   logic [NW-1:0]     scale_ff, scale_in;
   logic              unb_ff, unb_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              o_feas_ff, o_feas_in;
   logic              o_sv_ff, o_sv_in;
   logic              o_av_ff, o_av_in;
   logic              o_tv_ff, o_tv_in;
   logic [31:0]       o_ft_ff, o_ft_in;
   logic [31:0]       o_ps_ff, o_ps_in;
   logic [31:0]       o_pa_ff, o_pa_in;
   logic [23:0]       o_ts_ff, o_ts_in;
   logic              o_tu_ff, o_tu_in;

   // shared units
   logic              div_start, div_done;
   logic [NW-1:0]     div_num, div_quot;
   logic [31:0]       div_den;
   logic              sqrt_start, sqrt_done;
   logic [63:0]       sqrt_rad;
   logic [31:0]       sqrt_root;

   // scratch
   logic signed [MW-1:0] diff;
   logic [MW-1:0]        dmag;
   logic [NW-1:0]        cap;
   logic [NW-1:0]        vmag;
   logic signed [WW-1:0] comp;
   logic signed [WW-1:0] csel;
   logic [WW-1:0]        cmag;
   logic [63:0]          cmag64;
   logic [64:0]          nsum;
   logic [31:0]          norm;

   stlc_div #(.NUM_W(NW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   stlc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         slim_ff <= '0;
         sen_ff  <= 1'b0;
         alim_ff <= '0;
         aen_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPEED_LIMIT:  slim_ff <= csr_wdata;
            CSR_SPEED_ENABLE: sen_ff  <= csr_wdata[0];
            CSR_ACCEL_LIMIT:  alim_ff <= csr_wdata;
            CSR_ACCEL_ENABLE: aen_ff  <= csr_wdata[0];
            default:          slim_ff <= slim_ff;
         endcase
      end
   end

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      have_prev_in = have_prev_ff;
      prev_time_in = prev_time_ff;
      prev_pos_in  = prev_pos_ff;
      have_pvel_in = have_pvel_ff;
      pvel_in      = pvel_ff;
      pvel_time_in = pvel_time_ff;
      max_speed_in = max_speed_ff;
      max_accel_in = max_accel_ff;
      sflag_in     = sflag_ff;
      aflag_in     = aflag_ff;
      ftv_in       = ftv_ff;
      ft_in        = ft_ff;
      phase_acc_in = phase_acc_ff;
      idx_in       = idx_ff;
      den_in       = den_ff;
      mcand_in     = mcand_ff;
      prod_in      = prod_ff;
      mcnt_in      = mcnt_ff;
      neg_in       = neg_ff;
      vel_in       = vel_ff;
      accv_in      = accv_ff;
      sq_in        = sq_ff;
      big_in       = big_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      scale_in     = scale_ff;
      unb_in       = unb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_feas_in    = o_feas_ff;
      o_sv_in      = o_sv_ff;
      o_av_in      = o_av_ff;
      o_tv_in      = o_tv_ff;
      o_ft_in      = o_ft_ff;
      o_ps_in      = o_ps_ff;
      o_pa_in      = o_pa_ff;
      o_ts_in      = o_ts_ff;
      o_tu_in      = o_tu_ff;
      req_ready    = 1'b0;
      div_start    = 1'b0;
      div_num      = prod_ff;
      div_den      = den_ff;
      sqrt_start   = 1'b0;
      sqrt_rad     = sum_ff;

      // component difference for the current phase
      if (phase_acc_ff)
         diff = MW'(vel_ff[idx_ff]) - MW'(pvel_ff[idx_ff]);
      else
         diff = MW'(pos_ff[idx_ff]) - MW'(prev_pos_ff[idx_ff]);
      dmag = diff[MW-1] ? MW'(-diff) : MW'(diff);

      // saturate the quotient magnitude and restore the sign
      cap  = neg_ff ? CAP_NEG : CAP_POS;
      vmag = (div_quot > cap) ? cap : div_quot;
      comp = neg_ff ? WW'(-vmag) : WW'(vmag);

      // magnitude of the component being squared
      csel   = phase_acc_ff ? accv_ff[idx_ff] : vel_ff[idx_ff];
      cmag   = csel[WW-1] ? WW'(-csel) : WW'(csel);
      cmag64 = 64'(cmag);
      nsum   = {1'b0, sum_ff} + {1'b0, sq_ff};
      norm   = ovf_ff ? NORM_MAX : sqrt_root;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               t_in      = req_sample_time;
               pos_in[0] = req_pos_x;
               pos_in[1] = req_pos_y;
               pos_in[2] = req_pos_z;
               last_in   = req_last_sample;
               // start a new run
               if (req_first_sample) begin
                  have_prev_in = 1'b0;
                  prev_time_in = '0;
                  prev_pos_in  = '{default: '0};
                  have_pvel_in = 1'b0;
                  pvel_in      = '{default: '0};
                  pvel_time_in = '0;
                  max_speed_in = '0;
                  max_accel_in = '0;
                  sflag_in     = 1'b0;
                  aflag_in     = 1'b0;
                  ftv_in       = 1'b0;
                  ft_in        = '0;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (have_prev_ff && t_ff > prev_time_ff) begin
               den_in       = t_ff - prev_time_ff;
               phase_acc_in = 1'b0;
               idx_in       = '0;
               state_in     = ST_DIFF;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIFF: begin
            neg_in   = diff[MW-1];
            mcand_in = NW'(dmag);
            prod_in  = '0;
            mcnt_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // shift-add by the microsecond constant
            if (USEC_PER_SEC[mcnt_ff])
               prod_in = prod_ff + mcand_ff;
            mcand_in = {mcand_ff[NW-2:0], 1'b0};
            mcnt_in  = mcnt_ff + 1'b1;
            if (mcnt_ff == 5'(USEC_BITS - 1))
               state_in = ST_DIV;
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (phase_acc_ff)
                  accv_in[idx_ff] = comp;
               else
                  vel_in[idx_ff] = comp;
               if (idx_ff == 2'd2) begin
                  idx_in   = '0;
                  sum_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_SQ;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_DIFF;
               end
            end
         end
         ST_SQ: begin
            big_in   = |cmag64[63:32];
            sq_in    = cmag64[31:0] * cmag64[31:0];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in = nsum[63:0];
            ovf_in = ovf_ff | big_ff | nsum[64];
            if (idx_ff == 2'd2) begin
               state_in = ST_ROOT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SQ;
            end
         end
         ST_ROOT: begin
            sqrt_start = 1'b1;
            state_in   = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (sqrt_done) begin
               if (!phase_acc_ff) begin
                  if (norm > max_speed_ff)
                     max_speed_in = norm;
                  if (sen_ff && norm > slim_ff) begin
                     sflag_in = 1'b1;
                     if (!ftv_ff) begin
                        ftv_in = 1'b1;
                        ft_in  = t_ff;
                     end
                  end
                  if (have_pvel_ff && t_ff > pvel_time_ff) begin
                     den_in       = t_ff - pvel_time_ff;
                     phase_acc_in = 1'b1;
                     idx_in       = '0;
                     state_in     = ST_DIFF;
                  end else begin
                     state_in = ST_COMMIT_V;
                  end
               end else begin
                  if (norm > max_accel_ff)
                     max_accel_in = norm;
                  if (aen_ff && norm > alim_ff) begin
                     aflag_in = 1'b1;
                     if (!ftv_ff) begin
                        ftv_in = 1'b1;
                        ft_in  = t_ff;
                     end
                  end
                  state_in = ST_COMMIT_V;
               end
            end
         end
         ST_COMMIT_V: begin
            pvel_in      = vel_ff;
            pvel_time_in = t_ff;
            have_pvel_in = 1'b1;
            state_in     = ST_COMMIT;
         end
         ST_COMMIT: begin
            prev_pos_in  = pos_ff;
            prev_time_in = t_ff;
            have_prev_in = 1'b1;
            if (last_ff) begin
               scale_in = NW'(ONE_Q16);
               unb_in   = 1'b0;
               state_in = ST_FIN_S;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN_S: begin
            state_in = ST_FIN_A;
            if (sen_ff && max_speed_ff > slim_ff) begin
               if (slim_ff == '0) begin
                  unb_in = 1'b1;
               end else begin
                  div_start = 1'b1;
                  div_num   = NW'({max_speed_ff, 16'h0000});
                  div_den   = slim_ff;
                  state_in  = ST_FIN_S_WAIT;
               end
            end
         end
         ST_FIN_S_WAIT: begin
            if (div_done) begin
               if (div_quot > scale_ff)
                  scale_in = div_quot;
               state_in = ST_FIN_A;
            end
         end
         ST_FIN_A: begin
            state_in = ST_OUT;
            if (aen_ff && max_accel_ff > alim_ff) begin
               if (alim_ff == '0) begin
                  unb_in = 1'b1;
               end else begin
                  div_start = 1'b1;
                  div_num   = NW'({max_accel_ff, 32'h0000_0000});
                  div_den   = alim_ff;
                  state_in  = ST_FIN_A_WAIT;
               end
            end
         end
         ST_FIN_A_WAIT: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               sqrt_rad   = div_quot[63:0];
               state_in   = ST_FIN_A_ROOT;
            end
         end
         ST_FIN_A_ROOT: begin
            if (sqrt_done) begin
               if (NW'(sqrt_root) > scale_ff)
                  scale_in = NW'(sqrt_root);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               o_feas_in    = !(sflag_ff || aflag_ff);
               o_sv_in      = sflag_ff;
               o_av_in      = aflag_ff;
               o_tv_in      = ftv_ff;
               o_ft_in      = ftv_ff ? ft_ff : 32'h0;
               o_ps_in      = max_speed_ff;
               o_pa_in      = max_accel_ff;
               o_ts_in      = (unb_ff || scale_ff > NW'(SCALE_MAX)) ?
                              SCALE_MAX : scale_ff[23:0];
               o_tu_in      = unb_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         prev_time_ff <= '0;
         prev_pos_ff  <= '{default: '0};
         have_pvel_ff <= 1'b0;
         pvel_ff      <= '{default: '0};
         pvel_time_ff <= '0;
         max_speed_ff <= '0;
         max_accel_ff <= '0;
         sflag_ff     <= 1'b0;
         aflag_ff     <= 1'b0;
         ftv_ff       <= 1'b0;
         ft_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         have_prev_ff <= have_prev_in;
         prev_time_ff <= prev_time_in;
         prev_pos_ff  <= prev_pos_in;
         have_pvel_ff <= have_pvel_in;
         pvel_ff      <= pvel_in;
         pvel_time_ff <= pvel_time_in;
         max_speed_ff <= max_speed_in;
         max_accel_ff <= max_accel_in;
         sflag_ff     <= sflag_in;
         aflag_ff     <= aflag_in;
         ftv_ff       <= ftv_in;
         ft_ff        <= ft_in;
      end
   end

   // Payload and work registers
   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      pos_ff       <= pos_in;
      last_ff      <= last_in;
      phase_acc_ff <= phase_acc_in;
      idx_ff       <= idx_in;
      den_ff       <= den_in;
      mcand_ff     <= mcand_in;
      prod_ff      <= prod_in;
      mcnt_ff      <= mcnt_in;
      neg_ff       <= neg_in;
      vel_ff       <= vel_in;
      accv_ff      <= accv_in;
      sq_ff        <= sq_in;
      big_ff       <= big_in;
      sum_ff       <= sum_in;
      ovf_ff       <= ovf_in;
      scale_ff     <= scale_in;
      unb_ff       <= unb_in;
      o_feas_ff    <= o_feas_in;
      o_sv_ff      <= o_sv_in;
      o_av_ff      <= o_av_in;
      o_tv_ff      <= o_tv_in;
      o_ft_ff      <= o_ft_in;
      o_ps_ff      <= o_ps_in;
      o_pa_ff      <= o_pa_in;
      o_ts_ff      <= o_ts_in;
      o_tu_ff      <= o_tu_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_feasible             = o_feas_ff;
   assign rsp_speed_violation      = o_sv_ff;
   assign rsp_accel_violation      = o_av_ff;
   assign rsp_violation_time_valid = o_tv_ff;
   assign rsp_first_viol_time      = o_ft_ff;
   assign rsp_peak_speed           = o_ps_ff;
   assign rsp_peak_accel           = o_pa_ff;
   assign rsp_time_scale           = o_ts_ff;
   assign rsp_time_scale_unbounded = o_tu_ff;

endmodule
